>>> src/bounded_max_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// Bounded max-heap queue assertion macros
// Shared assertion macros for the heap queue checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_MAX_HEAP_QUEUE_DEFINES_SVH
`define BOUNDED_MAX_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BMHQ_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Heap queue package
// Types and codes shared by the heap queue controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam int VALUE_W = 32;
	localparam int CAP_W   = 7;

	typedef enum logic [1:0] {
		RES_DONE  = 2'd0,
		RES_FULL  = 2'd1,
		RES_EMPTY = 2'd2
	} result_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_REM_RD,
		ST_REM_LOAD,
		ST_KID_RD,
		ST_KID_CMP,
		ST_TOP_RD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic         accept;
		result_code_t status_code;
		logic         rd_parent;
		logic         rd_root_last;
		logic         load_remove;
		logic         rd_kids;
		logic         move_up;
		logic         move_down;
		logic         place;
		logic         inc_count;
		logic         rd_top;
		logic         emit;
	} dp_cmd_t;

	typedef struct packed {
		logic item_remove;
		logic full;
		logic empty;
		logic pos_zero;
		logic parent_less;
		logic leaf;
		logic child_more;
		logic slot_free;
	} dp_status_t;

endpackage

>>> src/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// Heap queue controller
// Sequences inserts with sift-up and removes with sift-down, one item at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bmhq_pkg::dp_status_t sts,
	output bmhq_pkg::dp_cmd_t    cmd
);

	bmhq_pkg::state_t state_q;
	bmhq_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next      = state_q;
		cmd             = '0;
		cmd.status_code = bmhq_pkg::RES_DONE;
		in_stall        = 1'b1;
		case (state_q)
			bmhq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!sts.item_remove) begin
						if (sts.full) begin
							cmd.status_code = bmhq_pkg::RES_FULL;
							state_next      = bmhq_pkg::ST_TOP_RD;
						end else begin
							state_next = bmhq_pkg::ST_INS_RD;
						end
					end else begin
						if (sts.empty) begin
							cmd.status_code = bmhq_pkg::RES_EMPTY;
							state_next      = bmhq_pkg::ST_TOP_RD;
						end else begin
							state_next = bmhq_pkg::ST_REM_RD;
						end
					end
				end
			end
			bmhq_pkg::ST_INS_RD: begin
				if (sts.pos_zero) begin
					cmd.place     = 1'b1;
					cmd.inc_count = 1'b1;
					state_next    = bmhq_pkg::ST_TOP_RD;
				end else begin
					cmd.rd_parent = 1'b1;
					state_next    = bmhq_pkg::ST_INS_CMP;
				end
			end
			bmhq_pkg::ST_INS_CMP: begin
				if (sts.parent_less) begin
					cmd.move_up = 1'b1;
					state_next  = bmhq_pkg::ST_INS_RD;
				end else begin
					cmd.place     = 1'b1;
					cmd.inc_count = 1'b1;
					state_next    = bmhq_pkg::ST_TOP_RD;
				end
			end
			bmhq_pkg::ST_REM_RD: begin
				cmd.rd_root_last = 1'b1;
				state_next       = bmhq_pkg::ST_REM_LOAD;
			end
			bmhq_pkg::ST_REM_LOAD: begin
				cmd.load_remove = 1'b1;
				state_next      = bmhq_pkg::ST_KID_RD;
			end
			bmhq_pkg::ST_KID_RD: begin
				if (sts.leaf) begin
					cmd.place  = 1'b1;
					state_next = bmhq_pkg::ST_TOP_RD;
				end else begin
					cmd.rd_kids = 1'b1;
					state_next  = bmhq_pkg::ST_KID_CMP;
				end
			end
			bmhq_pkg::ST_KID_CMP: begin
				if (sts.child_more) begin
					cmd.move_down = 1'b1;
					state_next    = bmhq_pkg::ST_KID_RD;
				end else begin
					cmd.place  = 1'b1;
					state_next = bmhq_pkg::ST_TOP_RD;
				end
			end
			bmhq_pkg::ST_TOP_RD: begin
				cmd.rd_top = 1'b1;
				state_next = bmhq_pkg::ST_FINISH;
			end
			bmhq_pkg::ST_FINISH: begin
				if (sts.slot_free) begin
					cmd.emit   = 1'b1;
					state_next = bmhq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bmhq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// Heap queue datapath
// Heap memory with two registered read ports, sift registers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              op,
	input  logic signed [bmhq_pkg::VALUE_W-1:0] value,
	input  logic                              cfg_wr_en,
	input  logic [bmhq_pkg::CAP_W-1:0]        capacity_limit,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [1:0]                        status,
	output logic signed [bmhq_pkg::VALUE_W-1:0] removed_value,
	output logic signed [bmhq_pkg::VALUE_W-1:0] top_value,
	output logic [bmhq_pkg::CAP_W-1:0]        element_total,
	input  bmhq_pkg::dp_cmd_t                 cmd,
	output bmhq_pkg::dp_status_t              sts
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = AW + 2;
	localparam int CMPW = (CW > bmhq_pkg::CAP_W) ? CW : bmhq_pkg::CAP_W;

	logic signed [bmhq_pkg::VALUE_W-1:0] mem [DEPTH];

	logic [bmhq_pkg::CAP_W-1:0]          capacity_q;
	logic [CW-1:0]                       count_q;
	logic                                out_valid_q;
	logic [AW-1:0]                       pos_q;
	logic signed [bmhq_pkg::VALUE_W-1:0] v_q;
	logic signed [bmhq_pkg::VALUE_W-1:0] removed_q;
	bmhq_pkg::result_code_t              code_q;
	logic signed [bmhq_pkg::VALUE_W-1:0] rd_a_q;
	logic signed [bmhq_pkg::VALUE_W-1:0] rd_b_q;
	logic [1:0]                          status_q;
	logic signed [bmhq_pkg::VALUE_W-1:0] removed_out_q;
	logic signed [bmhq_pkg::VALUE_W-1:0] top_out_q;
	logic [bmhq_pkg::CAP_W-1:0]          total_out_q;

	logic [AW-1:0]                       pos_m1;
	logic [AW-1:0]                       parent;
	logic [IW-1:0]                       lc;
	logic [IW-1:0]                       rc;
	logic [IW-1:0]                       count_ext;
	logic [CW-1:0]                       last;
	logic                                use_r;
	logic [IW-1:0]                       best_idx;
	logic signed [bmhq_pkg::VALUE_W-1:0] best_val;
	logic                                rd_en_a;
	logic                                rd_en_b;
	logic [AW-1:0]                       rd_addr_a;
	logic [AW-1:0]                       rd_addr_b;
	logic                                wr_en;
	logic signed [bmhq_pkg::VALUE_W-1:0] wr_data;

	assign pos_m1    = pos_q - AW'(1);
	assign parent    = pos_m1 >> 1;
	assign lc        = {1'b0, pos_q, 1'b1};
	assign rc        = {1'b0, pos_q, 1'b0} + IW'(2);
	assign count_ext = IW'(count_q);
	assign last      = count_q - CW'(1);
	assign use_r     = (rc < count_ext) && (rd_b_q > rd_a_q);
	assign best_idx  = use_r ? rc : lc;
	assign best_val  = use_r ? rd_b_q : rd_a_q;

	assign rd_en_a   = cmd.rd_parent | cmd.rd_kids | cmd.rd_root_last | cmd.rd_top;
	assign rd_en_b   = cmd.rd_kids | cmd.rd_root_last;
	assign rd_addr_a = cmd.rd_parent ? parent : (cmd.rd_kids ? lc[AW-1:0] : '0);
	assign rd_addr_b = cmd.rd_kids ? rc[AW-1:0] : last[AW-1:0];
	assign wr_en     = cmd.place | cmd.move_up | cmd.move_down;
	assign wr_data   = cmd.place ? v_q : (cmd.move_up ? rd_a_q : best_val);

	assign sts.item_remove = (op == bmhq_pkg::OP_REMOVE);
	assign sts.full        = (CMPW'(capacity_q) <= CMPW'(count_q)) || (count_q == CW'(DEPTH));
	assign sts.empty       = (count_q == '0);
	assign sts.pos_zero    = (pos_q == '0);
	assign sts.parent_less = (rd_a_q < v_q);
	assign sts.leaf        = (lc >= count_ext);
	assign sts.child_more  = (best_val > v_q);
	assign sts.slot_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (rd_en_a) begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= bmhq_pkg::CAP_W'(64);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= capacity_limit;
			end
			if (cmd.inc_count) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.load_remove) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q       <= value;
			pos_q     <= count_q[AW-1:0];
			removed_q <= '0;
			code_q    <= cmd.status_code;
		end
		if (cmd.load_remove) begin
			removed_q <= rd_a_q;
			v_q       <= rd_b_q;
			pos_q     <= '0;
		end
		if (cmd.move_up) begin
			pos_q <= parent;
		end
		if (cmd.move_down) begin
			pos_q <= best_idx[AW-1:0];
		end
		if (cmd.emit) begin
			status_q      <= code_q;
			removed_out_q <= removed_q;
			top_out_q     <= (count_q == '0) ? '0 : rd_a_q;
			total_out_q   <= bmhq_pkg::CAP_W'(count_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_out_q;
	assign top_value     = top_out_q;
	assign element_total = total_out_q;

endmodule

>>> src/bounded_max_heap_queue.sv
// An insert moves the element up by at most log2(DEPTH) heap levels and a remove moves it
// down by at most log2(DEPTH) - 1. A rejected operation goes straight to the top-of-heap read
// and the result load. One item is in work at a time; the next input transfer is taken only
// after the result is loaded. The heap memory has a single write port and two read ports.
// Reset empties the heap and sets the capacity to 64; the heap memory itself is not cleared.
// ----------------------------------------------------------------------------
// Bounded max-heap queue
// Binary max-heap priority queue of signed values with a programmable capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_max_heap_queue #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [bmhq_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [bmhq_pkg::VALUE_W-1:0] removed_value,
	output logic signed [bmhq_pkg::VALUE_W-1:0] top_value,
	output logic [bmhq_pkg::CAP_W-1:0]          element_total,
	input  logic                                cfg_wr_en,
	input  logic [bmhq_pkg::CAP_W-1:0]          capacity_limit
);

	bmhq_pkg::dp_cmd_t    cmd;
	bmhq_pkg::dp_status_t sts;

	bmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmhq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.value          (value),
		.cfg_wr_en      (cfg_wr_en),
		.capacity_limit (capacity_limit),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.removed_value  (removed_value),
		.top_value      (top_value),
		.element_total  (element_total),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

>>> src/bmhq_checker.sv
// ----------------------------------------------------------------------------
// Heap queue port checker
// Checks the heap queue ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_max_heap_queue_defines.svh"

module bmhq_checker #(
	parameter int DEPTH = 64
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [1:0]                          status,
	input logic signed [bmhq_pkg::VALUE_W-1:0] removed_value,
	input logic signed [bmhq_pkg::VALUE_W-1:0] top_value,
	input logic [bmhq_pkg::CAP_W-1:0]          element_total
);

	`BMHQ_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second item taken while busy")
	`BMHQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(element_total), "stalled result changed")
	`BMHQ_ASSERT(a_empty_result, out_valid && (status == bmhq_pkg::RES_EMPTY), (element_total == '0) && (top_value == '0) && (removed_value == '0), "empty reject result is not all zero")
	`BMHQ_ASSERT(a_total_bound, out_valid, (32'(element_total) <= DEPTH) && (status != 2'd3), "result count or code out of range")

endmodule

bind bounded_max_heap_queue bmhq_checker #(
	.DEPTH (DEPTH)
) u_bmhq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.removed_value (removed_value),
	.top_value     (top_value),
	.element_total (element_total)
);
